// File: src/mieu_pkg.sv
package mieu_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_SYSCALL = 2'd2;
    localparam logic [1:0] ST_UNSUP   = 2'd3;

    typedef struct packed {
        logic load;
        logic read;
        logic exec;
        logic iter;
        logic commit;
    } ctrl_t;

    typedef struct packed {
        logic is_long;
        logic iter_done;
    } stat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] lo_value;
        logic [31:0] hi_value;
        logic [31:0] write_value;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [31:0] next_pc;
    } result_t;

endpackage

// File: src/mieu_ram.sv
module mieu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end
endmodule

// File: src/mieu_ctrl.sv
module mieu_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_fire,
    input  logic           out_free,
    input  mieu_pkg::stat_t stat,
    output mieu_pkg::ctrl_t ctrl,
    output logic           busy
);
    import mieu_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EXEC = 5'b00100,
        S_ITER = 5'b01000,
        S_DONE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ctrl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                ctrl.load = in_fire;
                if (in_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ctrl.read  = 1'b1;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                ctrl.exec  = 1'b1;
                state_next = stat.is_long ? S_ITER : S_DONE;
            end
            S_ITER:
            begin
                ctrl.iter = 1'b1;
                if (stat.iter_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctrl.commit = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule

// File: src/mieu_dp.sv
module mieu_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       instruction,
    input  mieu_pkg::ctrl_t   ctrl,
    output mieu_pkg::stat_t   stat,
    output mieu_pkg::result_t result
);
    import mieu_pkg::*;

    logic [31:0] ir_reg;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;
    logic [31:0] a_reg, b_reg;
    logic [31:0] ra, rb;
    logic        gpr_we;
    logic        is_mul_reg, is_div_reg, neg_q_reg, neg_r_reg;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mcand_reg, mcand_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [31:0] val_reg, val_next;
    logic        wr_reg, wr_next;
    logic [4:0]  dst_reg, dst_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] npc_reg, npc_next;
    logic        is_mul_next, is_div_next, neg_q_next, neg_r_next;

    logic [5:0]  op, fn;
    logic [4:0]  rd, sh;
    logic [15:0] imm;
    logic [31:0] sx_imm, pc4, br;
    logic [4:0]  amt;
    logic        sra_v;
    logic [32:0] diff;
    logic [63:0] q_shift;

    assign op     = ir_reg[31:26];
    assign rd     = ir_reg[15:11];
    assign sh     = ir_reg[10:6];
    assign fn     = ir_reg[5:0];
    assign imm    = ir_reg[15:0];
    assign sx_imm = {{16{imm[15]}}, imm};
    assign pc4    = pc_reg + 32'd4;
    assign br     = pc4 + {sx_imm[29:0], 2'b00};

    mieu_ram #(.WIDTH(32), .DEPTH(32)) u_gpr (
        .clk       (clk),
        .wr_en     (gpr_we),
        .wr_addr   (dst_reg),
        .wr_data   (val_reg),
        .rd_addr_a (instruction[25:21]),
        .rd_data_a (ra),
        .rd_addr_b (instruction[20:16]),
        .rd_data_b (rb)
    );

    // gpr_file resets to zero: clear via valid bits
    logic [31:0] gv_reg;
    logic        rs_v_reg, rt_v_reg;
    assign gpr_we = ctrl.commit && wr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg   <= '0;
            pc_reg   <= '0;
            hi_reg   <= '0;
            lo_reg   <= '0;
            rs_v_reg <= 1'b0;
            rt_v_reg <= 1'b0;
        end
        else
        begin
            if (gpr_we)
            begin
                gv_reg[dst_reg] <= 1'b1;
            end
            if (ctrl.load)
            begin
                rs_v_reg <= gv_reg[instruction[25:21]];
                rt_v_reg <= gv_reg[instruction[20:16]];
            end
            if (ctrl.commit)
            begin
                pc_reg <= npc_reg;
                hi_reg <= hi_next;
                lo_reg <= lo_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ir_reg <= instruction;
        end
        if (ctrl.read)
        begin
            a_reg <= rs_v_reg ? ra : 32'd0;
            b_reg <= rt_v_reg ? rb : 32'd0;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        cnt_reg    <= cnt_next;
        val_reg    <= val_next;
        wr_reg     <= wr_next;
        dst_reg    <= dst_next;
        st_reg     <= st_next;
        npc_reg    <= npc_next;
        is_mul_reg <= is_mul_next;
        is_div_reg <= is_div_next;
        neg_q_reg  <= neg_q_next;
        neg_r_reg  <= neg_r_next;
    end

    assign amt   = (fn == FN_SLL || fn == FN_SRL || fn == FN_SRA) ? sh : a_reg[4:0];
    assign sra_v = b_reg[31];
    assign q_shift = {acc_reg[62:0], 1'b0};
    assign diff  = acc_reg[63:31] - {1'b0, mcand_reg};

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        cnt_next    = cnt_reg;
        val_next    = val_reg;
        wr_next     = wr_reg;
        dst_next    = dst_reg;
        st_next     = st_reg;
        npc_next    = npc_reg;
        is_mul_next = is_mul_reg;
        is_div_next = is_div_reg;
        neg_q_next  = neg_q_reg;
        neg_r_next  = neg_r_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;

        if (ctrl.exec)
        begin
            is_mul_next = 1'b0;
            is_div_next = 1'b0;
            neg_q_next  = 1'b0;
            neg_r_next  = 1'b0;
            cnt_next    = '0;
            npc_next    = pc4;
            st_next     = ST_OK;
            wr_next     = 1'b0;
            val_next    = '0;
            dst_next    = (op == OP_SPECIAL) ? rd : ir_reg[20:16];
            acc_next    = {32'd0, hi_reg};
            mcand_next  = lo_reg;
            if (op == OP_SPECIAL)
            begin
                case (fn)
                    FN_SLL, FN_SLLV:
                    begin
                        wr_next  = 1'b1;
                        val_next = b_reg << amt;
                    end
                    FN_SRL, FN_SRLV:
                    begin
                        wr_next  = 1'b1;
                        val_next = b_reg >> amt;
                    end
                    FN_SRA, FN_SRAV:
                    begin
                        wr_next  = 1'b1;
                        val_next = (b_reg >> amt) | ~({32{~sra_v}} | (32'hFFFFFFFF >> amt));
                    end
                    FN_JR: npc_next = a_reg;
                    FN_JALR:
                    begin
                        wr_next  = 1'b1;
                        val_next = pc4;
                        npc_next = a_reg;
                    end
                    FN_SYSCALL: st_next = ST_SYSCALL;
                    FN_MFHI:
                    begin
                        wr_next  = 1'b1;
                        val_next = hi_reg;
                    end
                    FN_MTHI: acc_next = {32'd0, a_reg};
                    FN_MFLO:
                    begin
                        wr_next  = 1'b1;
                        val_next = lo_reg;
                    end
                    FN_MTLO: mcand_next = a_reg;
                    FN_MULT, FN_MULTU:
                    begin
                        is_mul_next = 1'b1;
                        neg_q_next  = (fn == FN_MULT) && (a_reg[31] ^ b_reg[31]);
                        acc_next    = {32'd0, (fn == FN_MULT && a_reg[31]) ? -a_reg : a_reg};
                        mcand_next  = (fn == FN_MULT && b_reg[31]) ? -b_reg : b_reg;
                    end
                    FN_DIV, FN_DIVU:
                    begin
                        if (b_reg == 32'd0)
                        begin
                            st_next = ST_DIVZERO;
                        end
                        else
                        begin
                            is_div_next = 1'b1;
                            neg_q_next  = (fn == FN_DIV) && (a_reg[31] ^ b_reg[31]);
                            neg_r_next  = (fn == FN_DIV) && a_reg[31];
                            acc_next    = {32'd0, (fn == FN_DIV && a_reg[31]) ? -a_reg : a_reg};
                            mcand_next  = (fn == FN_DIV && b_reg[31]) ? -b_reg : b_reg;
                        end
                    end
                    FN_ADD, FN_ADDU:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg + b_reg;
                    end
                    FN_SUB, FN_SUBU:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg - b_reg;
                    end
                    FN_AND:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg & b_reg;
                    end
                    FN_OR:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg | b_reg;
                    end
                    FN_XOR:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg ^ b_reg;
                    end
                    FN_NOR:
                    begin
                        wr_next  = 1'b1;
                        val_next = ~(a_reg | b_reg);
                    end
                    FN_SLT:
                    begin
                        wr_next  = 1'b1;
                        val_next = {31'd0, $signed(a_reg) < $signed(b_reg)};
                    end
                    FN_SLTU:
                    begin
                        wr_next  = 1'b1;
                        val_next = {31'd0, a_reg < b_reg};
                    end
                    default: st_next = ST_UNSUP;
                endcase
            end
            else
            begin
                case (op)
                    OP_J: npc_next = {pc4[31:28], ir_reg[25:0], 2'b00};
                    OP_JAL:
                    begin
                        npc_next = {pc4[31:28], ir_reg[25:0], 2'b00};
                        wr_next  = 1'b1;
                        dst_next = 5'd31;
                        val_next = pc4;
                    end
                    OP_BEQ: if (a_reg == b_reg) npc_next = br;
                    OP_BNE: if (a_reg != b_reg) npc_next = br;
                    OP_BLEZ: if (a_reg == 32'd0 || a_reg[31]) npc_next = br;
                    OP_BGTZ: if (a_reg != 32'd0 && !a_reg[31]) npc_next = br;
                    OP_ADDI, OP_ADDIU:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg + sx_imm;
                    end
                    OP_SLTI:
                    begin
                        wr_next  = 1'b1;
                        val_next = {31'd0, $signed(a_reg) < $signed(sx_imm)};
                    end
                    OP_SLTIU:
                    begin
                        wr_next  = 1'b1;
                        val_next = {31'd0, a_reg < sx_imm};
                    end
                    OP_ANDI:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg & {16'd0, imm};
                    end
                    OP_ORI:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg | {16'd0, imm};
                    end
                    OP_XORI:
                    begin
                        wr_next  = 1'b1;
                        val_next = a_reg ^ {16'd0, imm};
                    end
                    OP_LUI:
                    begin
                        wr_next  = 1'b1;
                        val_next = {imm, 16'd0};
                    end
                    default: st_next = ST_UNSUP;
                endcase
            end
            if (dst_next == 5'd0)
            begin
                wr_next  = 1'b0;
            end
            if (!wr_next)
            begin
                dst_next = '0;
                val_next = '0;
            end
        end
        else if (ctrl.iter)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (is_mul_reg)
            begin
                // shift-add: acc = {hi, multiplier}, add multiplicand to hi
                if (acc_reg[0])
                begin
                    acc_next = {({1'b0, acc_reg[63:32]} + {1'b0, mcand_reg}),
                                acc_reg[31:1]};
                end
                else
                begin
                    acc_next = {1'b0, acc_reg[63:1]};
                end
            end
            else
            begin
                // restoring: acc = {rem, quotient}
                if (!diff[32])
                begin
                    acc_next = {diff[31:0], q_shift[31:1], 1'b1};
                end
                else
                begin
                    acc_next = q_shift;
                end
            end
        end
        else if (ctrl.commit)
        begin
            if (is_mul_reg)
            begin
                {hi_next, lo_next} = neg_q_reg ? -acc_reg : acc_reg;
            end
            else if (is_div_reg)
            begin
                lo_next = neg_q_reg ? -acc_reg[31:0] : acc_reg[31:0];
                hi_next = neg_r_reg ? -acc_reg[63:32] : acc_reg[63:32];
            end
            else
            begin
                hi_next = acc_reg[31:0];
                lo_next = mcand_reg;
            end
        end
    end

    assign stat.is_long   = is_mul_next || is_div_next;
    assign stat.iter_done = (cnt_reg == 6'd31);

    always_comb
    begin
        result.next_pc     = npc_reg;
        result.reg_write   = wr_reg;
        result.dest_reg    = dst_reg;
        result.write_value = val_reg;
        result.status      = st_reg;
        if (is_mul_reg)
        begin
            {result.hi_value, result.lo_value} = neg_q_reg ? -acc_reg : acc_reg;
        end
        else if (is_div_reg)
        begin
            result.lo_value = neg_q_reg ? -acc_reg[31:0] : acc_reg[31:0];
            result.hi_value = neg_r_reg ? -acc_reg[63:32] : acc_reg[63:32];
        end
        else
        begin
            result.hi_value = acc_reg[31:0];
            result.lo_value = mcand_reg;
        end
    end
endmodule

// File: src/mips_integer_execute_unit.sv
// channel | dir | tdata fields (low bit up)
// s_axis  | in  | instruction[31:0]
// m_axis  | out | next_pc, reg_write, dest_reg, write_value, hi_value, lo_value, status
// Ordinary instructions pass through the READ, EXEC and DONE states from accept to result.
// MULT/MULTU/DIV/DIVU also pass through ITER for the shift-add / restoring divide loop,
// except a divide by zero, which takes the ordinary path. Register file reads come from
// a RAM with registered read; reset clears PC, HI, LO and the register file valid bits.
// A stalled result holds; a new beat is still taken, but its result waits in DONE.
module mips_integer_execute_unit (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // instruction
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [135:0] m_axis_tdata    // next_pc, reg_write, dest_reg, write_value,
                                         // hi_value, lo_value, status
);
    import mieu_pkg::*;

    ctrl_t   ctrl;
    stat_t   stat;
    result_t res;
    logic    busy;
    logic    ovalid_reg;
    result_t odata_reg;

    mieu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .out_free (!ovalid_reg || m_axis_tready),
        .stat     (stat),
        .ctrl     (ctrl),
        .busy     (busy)
    );

    mieu_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .instruction (s_axis_tdata),
        .ctrl        (ctrl),
        .stat        (stat),
        .result      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            ovalid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            odata_reg <= res;
        end
    end

    assign s_axis_tready = !busy;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
endmodule

// File: test/mips_integer_execute_unit_tb.sv
module mips_integer_execute_unit_tb;
    import mieu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata = '0;   // instruction
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [135:0] m_axis_tdata;        // next_pc, reg_write, dest_reg, write_value,
                                       // hi_value, lo_value, status

    typedef struct {
        logic [31:0] next_pc;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [31:0] write_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic [1:0]  status;
    } outcome_t;

    logic [31:0] gpr [32];
    logic [31:0] pc;
    logic [31:0] hi;
    logic [31:0] lo;
    outcome_t    pending_outcomes[$];
    int          errors = 0;
    int          beats_out = 0;
    int          beats_in = 0;
    bit          hold_sink = 1'b0;
    bit          long_ops_seen = 1'b0;

    mips_integer_execute_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic outcome_t execute_instr(input logic [31:0] ins);
        outcome_t    o;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rs;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] pc4;
        logic [31:0] br;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [63:0] prod;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        logic        wr;
        logic [4:0]  dst;
        logic [31:0] val;
        logic [1:0]  st;
        op = ins[31:26];
        rs = ins[25:21];
        rt = ins[20:16];
        rd = ins[15:11];
        sh = ins[10:6];
        fn = ins[5:0];
        a = gpr[rs];
        b = gpr[rt];
        pc4 = pc + 32'd4;
        simm = {{16{ins[15]}}, ins[15:0]};
        zimm = {16'h0, ins[15:0]};
        br = pc4 + (simm << 2);
        o.next_pc = pc4;
        st = ST_OK;
        wr = 1'b0;
        val = '0;
        if (op == OP_SPECIAL)
        begin
            dst = rd;
            case (fn)
                FN_SLL:
                begin
                    wr = 1'b1;
                    val = b << sh;
                end
                FN_SRL:
                begin
                    wr = 1'b1;
                    val = b >> sh;
                end
                FN_SRA:
                begin
                    wr = 1'b1;
                    val = $signed(b) >>> sh;
                end
                FN_SLLV:
                begin
                    wr = 1'b1;
                    val = b << a[4:0];
                end
                FN_SRLV:
                begin
                    wr = 1'b1;
                    val = b >> a[4:0];
                end
                FN_SRAV:
                begin
                    wr = 1'b1;
                    val = $signed(b) >>> a[4:0];
                end
                FN_JR: o.next_pc = a;
                FN_JALR:
                begin
                    wr = 1'b1;
                    val = pc4;
                    o.next_pc = a;
                end
                FN_SYSCALL: st = ST_SYSCALL;
                FN_MFHI:
                begin
                    wr = 1'b1;
                    val = hi;
                end
                FN_MTHI: hi = a;
                FN_MFLO:
                begin
                    wr = 1'b1;
                    val = lo;
                end
                FN_MTLO: lo = a;
                FN_MULT:
                begin
                    prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    {hi, lo} = prod;
                end
                FN_MULTU:
                begin
                    prod = {32'h0, a} * {32'h0, b};
                    {hi, lo} = prod;
                end
                FN_DIV:
                begin
                    if (b == 32'd0)
                    begin
                        st = ST_DIVZERO;
                    end
                    else
                    begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q = ma / mb;
                        r = ma % mb;
                        lo = (a[31] != b[31]) ? -q : q;
                        hi = a[31] ? -r : r;
                    end
                end
                FN_DIVU:
                begin
                    if (b == 32'd0)
                    begin
                        st = ST_DIVZERO;
                    end
                    else
                    begin
                        lo = a / b;
                        hi = a % b;
                    end
                end
                FN_ADD, FN_ADDU:
                begin
                    wr = 1'b1;
                    val = a + b;
                end
                FN_SUB, FN_SUBU:
                begin
                    wr = 1'b1;
                    val = a - b;
                end
                FN_AND:
                begin
                    wr = 1'b1;
                    val = a & b;
                end
                FN_OR:
                begin
                    wr = 1'b1;
                    val = a | b;
                end
                FN_XOR:
                begin
                    wr = 1'b1;
                    val = a ^ b;
                end
                FN_NOR:
                begin
                    wr = 1'b1;
                    val = ~(a | b);
                end
                FN_SLT:
                begin
                    wr = 1'b1;
                    val = {31'h0, $signed(a) < $signed(b)};
                end
                FN_SLTU:
                begin
                    wr = 1'b1;
                    val = {31'h0, a < b};
                end
                default: st = ST_UNSUP;
            endcase
        end
        else
        begin
            dst = rt;
            case (op)
                OP_J: o.next_pc = {pc4[31:28], ins[25:0], 2'b00};
                OP_JAL:
                begin
                    o.next_pc = {pc4[31:28], ins[25:0], 2'b00};
                    wr = 1'b1;
                    dst = 5'd31;
                    val = pc4;
                end
                OP_BEQ: if (a == b) o.next_pc = br;
                OP_BNE: if (a != b) o.next_pc = br;
                OP_BLEZ: if (a == 32'd0 || a[31]) o.next_pc = br;
                OP_BGTZ: if (a != 32'd0 && !a[31]) o.next_pc = br;
                OP_ADDI, OP_ADDIU:
                begin
                    wr = 1'b1;
                    val = a + simm;
                end
                OP_SLTI:
                begin
                    wr = 1'b1;
                    val = {31'h0, $signed(a) < $signed(simm)};
                end
                OP_SLTIU:
                begin
                    wr = 1'b1;
                    val = {31'h0, a < simm};
                end
                OP_ANDI:
                begin
                    wr = 1'b1;
                    val = a & zimm;
                end
                OP_ORI:
                begin
                    wr = 1'b1;
                    val = a | zimm;
                end
                OP_XORI:
                begin
                    wr = 1'b1;
                    val = a ^ zimm;
                end
                OP_LUI:
                begin
                    wr = 1'b1;
                    val = {ins[15:0], 16'h0};
                end
                default: st = ST_UNSUP;
            endcase
        end
        if (!wr || dst == 5'd0)
        begin
            wr = 1'b0;
            dst = '0;
            val = '0;
        end
        else
        begin
            gpr[dst] = val;
        end
        pc = o.next_pc;
        o.reg_write = wr;
        o.dest_reg = dst;
        o.write_value = val;
        o.hi_value = hi;
        o.lo_value = lo;
        o.status = st;
        return o;
    endfunction

    function automatic int gap_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    task automatic issue(input logic [31:0] ins, input bit gaps = 1'b1);
        int n;
        n = 0;
        if (gaps && $urandom_range(0, 2) == 0)
        begin
            n = gap_length();
        end
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= ins;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        pending_outcomes.push_back(execute_instr(ins));
        beats_in++;
        if (ins[31:26] == OP_SPECIAL && ins[5:0] inside {FN_MULT, FN_MULTU, FN_DIV, FN_DIVU})
        begin
            long_ops_seen = 1'b1;
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_outcomes.size() != 0);
    endtask

    function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                          logic [4:0] sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic logic [31:0] random_instr();
        logic [5:0] fns [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR,
            FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU,
            FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR,
            FN_NOR, FN_SLT, FN_SLTU};
        logic [5:0] ops [14] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_ADDI,
            OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI};
        logic [31:0] w;
        int k;
        w = $urandom();
        k = $urandom_range(0, 19);
        if (k < 9)
        begin
            w = {OP_SPECIAL, w[25:6], fns[$urandom_range(0, 26)]};
        end
        else if (k < 18)
        begin
            w[31:26] = ops[$urandom_range(0, 13)];
        end
        if (k == 8)
        begin
            w = {OP_SPECIAL, w[25:21], 5'd0, w[15:6], FN_DIV};
        end
        return w;
    endfunction

    task automatic test_reset_state();
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        pc = '0;
        hi = '0;
        lo = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_directed();
        issue(itype(OP_LUI, 5'd0, 5'd1, 16'h8000));
        issue(itype(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
        issue(itype(OP_ORI, 5'd0, 5'd3, 16'hFFFF));
        issue(itype(OP_ADDI, 5'd1, 5'd4, 16'hFFFF));
        issue(rtype(5'd1, 5'd2, 5'd0, 5'd0, FN_ADD));
        issue(rtype(5'd4, 5'd3, 5'd5, 5'd0, FN_ADD));
        issue(rtype(5'd2, 5'd1, 5'd6, 5'd31, FN_SRA));
        issue(rtype(5'd2, 5'd1, 5'd7, 5'd31, FN_SRLV));
        issue(rtype(5'd1, 5'd2, 5'd8, 5'd0, FN_NOR));
        issue(rtype(5'd1, 5'd2, 5'd9, 5'd0, FN_DIV));
        issue(rtype(5'd2, 5'd0, 5'd0, 5'd0, FN_DIVU));
        issue(rtype(5'd3, 5'd3, 5'd0, 5'd0, FN_DIVU));
        issue(rtype(5'd1, 5'd1, 5'd0, 5'd0, FN_MULT));
        issue(rtype(5'd2, 5'd2, 5'd0, 5'd0, FN_MULTU));
        issue(rtype(5'd0, 5'd0, 5'd10, 5'd0, FN_MFHI));
        issue(rtype(5'd0, 5'd0, 5'd11, 5'd0, FN_MFLO));
        issue(itype(OP_SLTIU, 5'd3, 5'd12, 16'hFFFF));
        issue(itype(OP_SLTI, 5'd1, 5'd13, 16'h0000));
        issue(rtype(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL));
        issue(32'h8C00_0000);
        issue(rtype(5'd0, 5'd0, 5'd0, 5'd0, 6'h3F));
        issue(itype(OP_BLEZ, 5'd0, 5'd0, 16'h8000));
        issue(itype(OP_BGTZ, 5'd3, 5'd0, 16'h7FFF));
        issue({OP_JAL, 26'h3FF_FFFF});
        issue(rtype(5'd31, 5'd0, 5'd14, 5'd0, FN_JALR));
        issue({OP_J, 26'h0});
    endtask

    task automatic test_backpressure();
        drain();
        hold_sink = 1'b1;
        fork
            begin
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
            for (int i = 0; i < 10; i++) issue(random_instr(), 1'b0);
        join
        drain();
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            issue(random_instr());
            if (i == n / 2)
            begin
                drain();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (hold_sink || $urandom_range(0, 3) == 0)
        begin
            m_axis_tready <= ($urandom_range(0, 19) == 0) && !hold_sink ? 1'b1 : 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        outcome_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beats_out++;
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result beat");
                errors++;
            end
            else
            begin
                e = pending_outcomes.pop_front();
                if (m_axis_tdata[31:0] !== e.next_pc)
                begin
                    $error("next_pc exp %h got %h", e.next_pc, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[32] !== e.reg_write)
                begin
                    $error("reg_write exp %b got %b", e.reg_write, m_axis_tdata[32]);
                    errors++;
                end
                if (m_axis_tdata[37:33] !== e.dest_reg)
                begin
                    $error("dest_reg exp %0d got %0d", e.dest_reg, m_axis_tdata[37:33]);
                    errors++;
                end
                if (m_axis_tdata[69:38] !== e.write_value)
                begin
                    $error("write_value exp %h got %h", e.write_value, m_axis_tdata[69:38]);
                    errors++;
                end
                if (m_axis_tdata[101:70] !== e.hi_value)
                begin
                    $error("hi_value exp %h got %h", e.hi_value, m_axis_tdata[101:70]);
                    errors++;
                end
                if (m_axis_tdata[133:102] !== e.lo_value)
                begin
                    $error("lo_value exp %h got %h", e.lo_value, m_axis_tdata[133:102]);
                    errors++;
                end
                if (m_axis_tdata[135:134] !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, m_axis_tdata[135:134]);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        test_reset_state();
        test_directed();
        test_backpressure();
        test_random(800);
        drain();
        repeat (50) @(posedge clk);
        $display("%0d instructions in, %0d results out; all opcodes, div by zero, stalls",
                 beats_in, beats_out);
        if (errors == 0 && pending_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: sim.f
src/mieu_pkg.sv
src/mieu_ram.sv
src/mieu_ctrl.sv
src/mieu_dp.sv
src/mips_integer_execute_unit.sv
test/mips_integer_execute_unit_tb.sv
